// File: sv/oca_pkg.sv
// ----------------------------------------------------------------------------
// oca_pkg
// Shared types and constants of the override chain audibility gate.
// ----------------------------------------------------------------------------
package oca_pkg;

  localparam int LaneSlotsDef = 16;
  localparam int IdW          = 32;
  localparam int TimeW        = 48;
  localparam int HoldW        = 16;

  // request actions
  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_QUERY = 2'd1;
  localparam logic [1:0] ACT_NOTE  = 2'd2;

  // configuration register indexes
  localparam logic CFG_MODE = 1'b0;
  localparam logic CFG_HOLD = 1'b1;

  typedef struct packed {
    logic [1:0]       action;
    logic [IdW-1:0]   lane_id;
    logic [IdW-1:0]   override_target;
    logic [TimeW-1:0] now_ms;
    logic             audible;
    logic             last_entry;
  } in_t;

  typedef struct packed {
    logic play;
    logic status;
  } out_t;

endpackage

// File: sv/oca_table.sv
// ----------------------------------------------------------------------------
// oca_table
// Two banks of lane entries; one is live, the other fills as shadow. Commit
// swaps the banks. The live bank is read at one scan index per cycle.
// ----------------------------------------------------------------------------
module oca_table import oca_pkg::*; #(
  parameter int LaneSlots = LaneSlotsDef,
  localparam int IW = $clog2(LaneSlots)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IW-1:0]    rd_idx_i,
  output logic [IdW-1:0]   rd_id_o,
  output logic [IdW-1:0]   rd_tgt_o,
  output logic [TimeW-1:0] rd_heard_o,
  input  logic             sh_we_i,
  input  logic [IW-1:0]    sh_idx_i,
  input  logic [IdW-1:0]   sh_id_i,
  input  logic [IdW-1:0]   sh_tgt_i,
  input  logic [TimeW-1:0] sh_heard_i,
  input  logic             note_we_i,
  input  logic [IW-1:0]    note_idx_i,
  input  logic [TimeW-1:0] note_heard_i,
  input  logic             commit_i
);

  logic [IdW-1:0]   ids_q   [2][LaneSlots];
  logic [IdW-1:0]   tgts_q  [2][LaneSlots];
  logic [TimeW-1:0] heard_q [2][LaneSlots];
  logic             sel_q;

  // swap live and shadow on commit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 1'b0;
    end else if (commit_i) begin
      sel_q <= ~sel_q;
    end
  end

  // write shadow entries and live heard stamps
  always_ff @(posedge clk_i) begin
    if (sh_we_i) begin
      ids_q[~sel_q][sh_idx_i]   <= sh_id_i;
      tgts_q[~sel_q][sh_idx_i]  <= sh_tgt_i;
      heard_q[~sel_q][sh_idx_i] <= sh_heard_i;
    end
    if (note_we_i) begin
      heard_q[sel_q][note_idx_i] <= note_heard_i;
    end
  end

  assign rd_id_o    = ids_q[sel_q][rd_idx_i];
  assign rd_tgt_o   = tgts_q[sel_q][rd_idx_i];
  assign rd_heard_o = heard_q[sel_q][rd_idx_i];

endmodule

// File: sv/override_chain_audibility_gate.sv
// ----------------------------------------------------------------------------
// override_chain_audibility_gate
// Lane table with shadow load, override lookup and fallback chain walk.
// ----------------------------------------------------------------------------
// Every request scans the live table one entry per cycle through a single
// compare unit before its result is registered. A fallback-mode query for an
// overridden lane then walks the override chain: each step rescans the table
// and then checks the silence, for at most live_count steps. The block takes
// no request until the result is in the output register; a waiting result
// does not block the next request.
module override_chain_audibility_gate import oca_pkg::*; #(
  parameter int LaneSlots = LaneSlotsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [HoldW-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_t              in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_t             out_data_o
);

  localparam int IW = $clog2(LaneSlots);
  localparam int CW = $clog2(LaneSlots + 1);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_WALK, S_CHECK, S_OUT} state_e;

  state_e           state_q;
  in_t              item_q;
  logic [CW-1:0]    idx_q, step_q, live_cnt_q, sh_cnt_q;
  logic             found_q, over_q, play_q, status_q;
  logic [IW-1:0]    fidx_q;
  logic [TimeW-1:0] fheard_q, kheard_q;
  logic [IdW-1:0]   cur_q, kid_q;
  logic             mode_q;
  logic [HoldW-1:0] hold_q;
  logic             out_valid_q;
  out_t             out_q;

  logic [IdW-1:0]   rd_id, rd_tgt;
  logic [TimeW-1:0] rd_heard, silent;
  logic             scan_end, sh_full, sh_we, note_we, commit;

  assign scan_end = (idx_q == live_cnt_q);
  assign sh_full  = (sh_cnt_q == CW'(LaneSlots));
  assign sh_we    = (state_q == S_SCAN) && scan_end && (item_q.action == ACT_LOAD)
                    && !sh_full;
  assign commit   = (state_q == S_SCAN) && scan_end && (item_q.action == ACT_LOAD)
                    && item_q.last_entry;
  assign note_we  = (state_q == S_SCAN) && scan_end && (item_q.action == ACT_NOTE)
                    && found_q && item_q.audible;
  assign silent   = (item_q.now_ms > kheard_q) ? item_q.now_ms - kheard_q : '0;

  oca_table #(.LaneSlots(LaneSlots)) u_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_idx_i    (idx_q[IW-1:0]),
    .rd_id_o     (rd_id),
    .rd_tgt_o    (rd_tgt),
    .rd_heard_o  (rd_heard),
    .sh_we_i     (sh_we),
    .sh_idx_i    (sh_cnt_q[IW-1:0]),
    .sh_id_i     (item_q.lane_id),
    .sh_tgt_i    (item_q.override_target),
    .sh_heard_i  (found_q ? fheard_q : item_q.now_ms),
    .note_we_i   (note_we),
    .note_idx_i  (fidx_q),
    .note_heard_i(item_q.now_ms),
    .commit_i    (commit)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b1;
      hold_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MODE: mode_q <= cfg_data_i[0];
        CFG_HOLD: hold_q <= cfg_data_i;
        default:  ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      live_cnt_q  <= '0;
      sh_cnt_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && state_q != S_OUT) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            item_q   <= in_data_i;
            idx_q    <= '0;
            found_q  <= 1'b0;
            over_q   <= 1'b0;
            play_q   <= 1'b0;
            status_q <= 1'b0;
            state_q  <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (!scan_end) begin
            // compare one live entry against the request id
            if (rd_id == item_q.lane_id && !found_q) begin
              found_q  <= 1'b1;
              fidx_q   <= idx_q[IW-1:0];
              fheard_q <= rd_heard;
            end
            if (rd_tgt != '0 && rd_id != '0 && rd_tgt != rd_id
                && rd_tgt == item_q.lane_id) over_q <= 1'b1;
            idx_q <= idx_q + 1'b1;
          end else begin
            state_q <= S_OUT;
            case (item_q.action)
              ACT_LOAD: begin
                status_q <= sh_full;
                if (item_q.last_entry) begin
                  live_cnt_q <= sh_full ? sh_cnt_q : sh_cnt_q + 1'b1;
                  sh_cnt_q   <= '0;
                end else if (!sh_full) begin
                  sh_cnt_q <= sh_cnt_q + 1'b1;
                end
              end
              ACT_QUERY: begin
                if (!found_q || !over_q) begin
                  play_q <= 1'b1;
                end else if (!mode_q) begin
                  cur_q   <= item_q.lane_id;
                  step_q  <= '0;
                  idx_q   <= '0;
                  state_q <= S_WALK;
                end
              end
              default: ;
            endcase
          end
        end
        S_WALK: begin
          // find the first overrider of the current id
          if (step_q == live_cnt_q || scan_end) begin
            play_q  <= 1'b1;
            state_q <= S_OUT;
          end else if (rd_tgt == cur_q) begin
            kheard_q <= rd_heard;
            kid_q    <= rd_id;
            state_q  <= S_CHECK;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_CHECK: begin
          // overrider still recent: silence, else advance along the chain
          if (silent < TimeW'(hold_q)) begin
            play_q  <= 1'b0;
            state_q <= S_OUT;
          end else begin
            cur_q   <= kid_q;
            step_q  <= step_q + 1'b1;
            idx_q   <= '0;
            state_q <= S_WALK;
          end
        end
        S_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_q       <= '{play: play_q, status: status_q};
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
